// ===== sv/prr_pkg.sv =====
// Package: shared types and constants of the polyphase rational resampler.
package prr_pkg;

   localparam int unsigned SampleW   = 24;
   localparam int unsigned CoefW     = 18;
   localparam int unsigned CntW      = 40;
   localparam int unsigned ResMax    = 64;
   localparam int unsigned MaxPhases = 256;
   localparam int unsigned MaxHalf   = 64;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_SAMPLE = 2'd1,
      MODE_FLUSH  = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_UP   = 2'd0,
      REG_DOWN = 2'd1,
      REG_HALF = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CHECK,
      BK_FETCH,
      BK_MAC,
      BK_FINISH,
      BK_ADVANCE
   } back_state_type;

   // One entry of the queue between the front and the back part.
   typedef struct packed {
      logic                      is_load;
      logic                      is_feed;
      logic signed [SampleW-1:0] value;
      logic [14:0]               addr;
      logic signed [CoefW-1:0]   coef;
   } work_type;

endpackage

// ===== sv/prr_if.sv =====
// Interfaces: input item channel and result item channel.
interface prr_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                mode;
   logic [14:0]               coef_addr;
   logic signed [17:0]        coef_value;
   logic signed [23:0]        sample_in;
   modport source (output valid, mode, coef_addr, coef_value, sample_in, input ready);
   modport sink   (input valid, mode, coef_addr, coef_value, sample_in, output ready);
endinterface

interface prr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] sample_out;
   logic               is_last;
   modport source (output valid, sample_out, is_last, input ready);
   modport sink   (input valid, sample_out, is_last, output ready);
endinterface

// ===== sv/polyphase_rational_resampler_unit.sv =====
// Top level: polyphase rational resampler with APB-style register port.
// Output: each output is held until the next one is computed; it leaves when that next output
// is finished, or when the end of the signal is seen.
// Pacing: the back part takes a queued item only while idle, so it finishes each output before
// taking the next item; the MAC loop over coefficient memory and history ring sets the pace.
// Reset: synchronous, active high; clears history, counters and queue; coefficients undefined.
module polyphase_rational_resampler_unit (
   input  logic        clock,
   input  logic        reset,
   prr_req_if.sink     req,
   prr_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import prr_pkg::*;

   logic [8:0]  up_ff;
   logic [15:0] down_ff;
   logic [6:0]  half_ff;
   work_type    q_data;
   logic        q_valid, q_pop;
   logic        wr;
   logic [1:0]  ri;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign ri = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff <= 9'd1; down_ff <= 16'd1; half_ff <= 7'd32;
      end else if (wr) begin
         unique case (reg_index_type'(ri))
            REG_UP:   up_ff   <= csr_pwdata[8:0];
            REG_DOWN: down_ff <= csr_pwdata[15:0];
            REG_HALF: half_ff <= csr_pwdata[6:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(ri))
         REG_UP:   csr_prdata = 32'(up_ff);
         REG_DOWN: csr_prdata = 32'(down_ff);
         REG_HALF: csr_prdata = 32'(half_ff);
         default:  csr_prdata = '0;
      endcase
   end

   prr_front u_front (
      .clock, .reset, .req, .q_data, .q_valid, .q_pop
   );

   prr_back u_back (
      .clock, .reset, .q_data, .q_valid, .q_pop,
      .up_factor(up_ff), .down_factor(down_ff), .half_taps(half_ff), .rsp
   );
endmodule

// ===== sv/prr_front.sv =====
// Front part: accepts input items, classifies them and queues work for the back part.
module prr_front (
   input  logic          clock,
   input  logic          reset,
   prr_req_if.sink       req,
   output prr_pkg::work_type q_data,
   output logic          q_valid,
   input  logic          q_pop
);
   import prr_pkg::*;

   localparam int unsigned Depth = 4;
   work_type         mem_ff [Depth];
   logic [1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             push;
   work_type         item;

   assign req.ready = (cnt_ff != 3'(Depth));
   assign push      = req.valid && req.ready && (req.mode != MODE_NONE);

   always_comb begin
      item.is_load = (req.mode == MODE_LOAD);
      item.is_feed = (req.mode == MODE_SAMPLE);
      item.value   = req.sample_in;
      item.addr    = req.coef_addr;
      item.coef    = req.coef_value;
   end

   always_comb begin
      wr_in  = push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = q_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + (push ? 3'd1 : 3'd0) - (q_pop ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= item;
   end

   assign q_valid = (cnt_ff != 3'd0);
   assign q_data  = mem_ff[rd_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(Depth)) else $error("queue overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push && !q_pop |=> cnt_ff == $past(cnt_ff) + 3'd1) else $error("count slip");
endmodule

// ===== sv/prr_back.sv =====
// Back part: history ring, coefficient memory, MAC sequencer and output holding.
module prr_back (
   input  logic              clock,
   input  logic              reset,
   input  prr_pkg::work_type q_data,
   input  logic              q_valid,
   output logic              q_pop,
   input  logic [8:0]        up_factor,
   input  logic [15:0]       down_factor,
   input  logic [6:0]        half_taps,
   prr_rsp_if.source         rsp
);
   import prr_pkg::*;

   localparam int unsigned Stride = 2 * MaxHalf;
   localparam int unsigned TapW   = $clog2(Stride);
   localparam int unsigned PhW    = (MaxPhases > 1) ? $clog2(MaxPhases) : 1;
   localparam int unsigned StoreD = MaxPhases * Stride;
   localparam int unsigned AddrW  = $clog2(StoreD);
   localparam int unsigned HW     = $clog2(MaxHalf + 1);
   localparam int unsigned UpW    = $clog2(MaxPhases + 1);
   localparam int unsigned AccW   = 50;

   logic signed [CoefW-1:0]   coef_mem [StoreD];
   logic signed [SampleW-1:0] hist_mem [Stride];
   logic [Stride-1:0]         hvalid_ff;

   back_state_type state_ff, state_in;
   logic [CntW-1:0] real_ff, fed_ff, pos_ff;
   logic [PhW-1:0]  phase_ff;
   logic            done_ff;
   logic            held_ff;
   logic signed [SampleW-1:0] held_val_ff;

   logic [TapW:0]   tap_ff;
   logic signed [AccW-1:0] acc_ff;
   logic signed [CoefW-1:0]   c_rd_ff;
   logic signed [SampleW-1:0] h_rd_ff;
   logic            h_ok_ff, rd_v_ff;
   logic [6:0]      nres_ff;
   logic [16:0]     ph_ff;

   logic               ov_ff;
   logic signed [SampleW-1:0] ov_val_ff;
   logic               ov_last_ff;

   logic [HW-1:0]  h_eff;
   logic [UpW-1:0] up_eff;
   logic [15:0]    dn_eff;
   logic           ended;
   logic           can_emit;

   always_comb begin
      if (half_taps == 7'd0) h_eff = HW'(1);
      else if (32'(half_taps) > MaxHalf) h_eff = HW'(MaxHalf);
      else h_eff = HW'(half_taps);
      if (up_factor == 9'd0) up_eff = UpW'(1);
      else if (32'(up_factor) > MaxPhases) up_eff = UpW'(MaxPhases);
      else up_eff = UpW'(up_factor);
      dn_eff = (down_factor == 16'd0) ? 16'd1 : down_factor;
   end

   assign ended    = (fed_ff != real_ff);
   assign can_emit = !ov_ff || rsp.ready;
   assign q_pop    = (state_ff == BK_IDLE) && q_valid &&
                     (q_data.is_load || done_ff || can_emit);

   logic [TapW:0]  ntap;
   logic [TapW-1:0] hidx, tapi;
   logic [AddrW-1:0] caddr;
   logic last_tap, final_now, out_ready, res_room;
   always_comb begin
      ntap     = (TapW+1)'(2) * (TapW+1)'(h_eff);
      tapi     = tap_ff[TapW-1:0];
      hidx     = TapW'(pos_ff + CntW'(1) + CntW'(tap_ff) + CntW'(Stride) - CntW'(h_eff));
      caddr    = AddrW'(AddrW'(phase_ff) * AddrW'(Stride) + AddrW'(tapi));
      last_tap = (tap_ff == ntap - 1'b1);
      final_now = ended && (pos_ff >= real_ff);
      res_room  = (nres_ff < 7'(ResMax));
      out_ready = (pos_ff + CntW'(h_eff) < fed_ff) && res_room;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:    if (q_pop && !q_data.is_load && !done_ff) state_in = BK_CHECK;
         BK_CHECK:   begin
            if (!can_emit) state_in = BK_CHECK;
            else if ((final_now && res_room) || !out_ready) state_in = BK_IDLE;
            else state_in = BK_FETCH;
         end
         BK_FETCH:   if (last_tap) state_in = BK_MAC;
         BK_MAC:     state_in = BK_FINISH;
         BK_FINISH:  state_in = BK_ADVANCE;
         BK_ADVANCE: if (ph_ff < 17'(up_eff)) state_in = BK_CHECK;
         default:    state_in = BK_IDLE;
      endcase
   end

   logic signed [SampleW-1:0] h_use;
   logic signed [SampleW+CoefW-1:0] mul;
   logic signed [AccW-1:0] prod, acc_nx, rnd;
   logic signed [SampleW-1:0] sat;
   always_comb begin
      h_use  = h_ok_ff ? h_rd_ff : '0;
      mul    = h_use * c_rd_ff;
      prod   = AccW'(mul);
      acc_nx = rd_v_ff ? acc_ff + prod : acc_ff;
      rnd    = (acc_nx + AccW'(32768)) >>> 16;
      if (rnd > AccW'(8388607)) sat = 24'sh7FFFFF;
      else if (rnd < -AccW'(8388608)) sat = 24'sh800000;
      else sat = rnd[SampleW-1:0];
   end

   logic ov_load;
   assign ov_load = held_ff && ((state_ff == BK_FINISH) ||
                    ((state_ff == BK_CHECK) && can_emit && final_now && res_room));

   always_ff @(posedge clock) begin
      if (q_pop && q_data.is_load) coef_mem[AddrW'(q_data.addr)] <= q_data.coef;
      if (q_pop && !q_data.is_load && !done_ff)
         hist_mem[TapW'(fed_ff)] <= (q_data.is_feed && !ended) ? q_data.value : '0;
      c_rd_ff <= coef_mem[caddr];
      h_rd_ff <= hist_mem[hidx];
      h_ok_ff <= hvalid_ff[hidx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         real_ff <= '0; fed_ff <= '0; pos_ff <= '0; phase_ff <= '0;
         done_ff <= 1'b0; held_ff <= 1'b0; hvalid_ff <= '0;
         ov_ff <= 1'b0; tap_ff <= '0; rd_v_ff <= 1'b0; nres_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (ov_ff && rsp.ready && !ov_load) ov_ff <= 1'b0;
         rd_v_ff <= (state_ff == BK_FETCH);
         if (q_pop && !q_data.is_load && !done_ff) begin
            hvalid_ff[TapW'(fed_ff)] <= 1'b1;
            if (q_data.is_feed && !ended) real_ff <= real_ff + 1'b1;
            fed_ff  <= fed_ff + 1'b1;
            nres_ff <= '0;
         end
         case (state_ff)
            BK_CHECK: begin
               tap_ff <= '0;
               acc_ff <= '0;
               if (can_emit && final_now && res_room) begin
                  done_ff <= 1'b1;
                  if (held_ff) begin
                     ov_ff <= 1'b1; ov_val_ff <= held_val_ff; ov_last_ff <= 1'b1;
                     held_ff <= 1'b0;
                  end
               end
            end
            BK_FETCH: begin
               tap_ff <= tap_ff + 1'b1;
               acc_ff <= acc_nx;
            end
            BK_MAC: begin
               acc_ff <= acc_nx;
               ph_ff  <= 17'(phase_ff) + 17'(dn_eff);
            end
            BK_FINISH: begin
               if (held_ff) begin
                  ov_ff <= 1'b1; ov_val_ff <= held_val_ff; ov_last_ff <= 1'b0;
                  nres_ff <= nres_ff + 1'b1;
               end
               held_ff <= 1'b1;
               held_val_ff <= sat;
               // step the phase one subtraction a cycle
               if (ph_ff < 17'(up_eff)) begin
                  phase_ff <= PhW'(ph_ff);
               end else begin
                  ph_ff  <= ph_ff - 17'(up_eff);
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            BK_ADVANCE: begin
               if (ph_ff < 17'(up_eff)) phase_ff <= PhW'(ph_ff);
               else begin
                  ph_ff  <= ph_ff - 17'(up_eff);
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid      = ov_ff;
   assign rsp.sample_out = ov_val_ff;
   assign rsp.is_last    = ov_last_ff;

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_last |-> done_ff) else $error("last before end");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
   a_fed_ge: assert property (@(posedge clock) disable iff (reset)
      fed_ff >= real_ff) else $error("count order");
endmodule

// ===== test/polyphase_rational_resampler_unit_tb.sv =====
// Testbench: checks the polyphase resampler against a behavioural predictor over random streams.
`timescale 1ns / 1ps

module polyphase_rational_resampler_unit_tb;
   import prr_pkg::*;

   localparam longint unsigned CountMask = (64'd1 << CntW) - 1;
   localparam int RingDepth  = 128;
   localparam int TapStride  = 128;
   localparam int SettleWait = 1000;

   typedef struct {
      logic signed [SampleW-1:0] value;
      logic                      last;
   } resampled_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   prr_req_if req_ch ();
   prr_rsp_if rsp_ch ();

   polyphase_rational_resampler_unit dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [CoefW-1:0]   coef_mem [0:32767];
   bit                        coef_written [0:32767];
   logic signed [SampleW-1:0] ring [0:RingDepth-1];
   longint unsigned real_cnt, fed_cnt, int_pos, phase;
   bit  sig_done, held_ok;
   logic signed [SampleW-1:0] held_value;
   int unsigned up_reg, down_reg, half_reg;

   resampled_type pending_outputs [$];
   int  mismatches, failures, results_seen, items_sent;
   bit  no_gaps;
   int  hold_request;
   int  hold_cnt, stall_cnt;

   function automatic int eff_up();
      if (up_reg == 0) return 1;
      return (up_reg > 256) ? 256 : int'(up_reg);
   endfunction

   function automatic int eff_down();
      return (down_reg == 0) ? 1 : int'(down_reg);
   endfunction

   function automatic int eff_half();
      if (half_reg == 0) return 1;
      return (half_reg > 64) ? 64 : int'(half_reg);
   endfunction

   function automatic int draw_gap();
      return no_gaps ? 0 : int'($urandom_range(0, 11));
   endfunction

   function automatic logic signed [SampleW-1:0] fir_output();
      longint acc;
      longint r;
      int h;
      int idx;
      h = eff_half();
      acc = 0;
      for (int t = 0; t < 2 * h; t++) begin
         idx = (int'(int_pos % RingDepth) + 1 + t + RingDepth - h) % RingDepth;
         acc += longint'(ring[idx]) * longint'(coef_mem[(int'(phase) * TapStride + t) % 32768]);
      end
      r = (acc + 32768) >>> 16;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[SampleW-1:0];
   endfunction

   task automatic push_output(input logic signed [SampleW-1:0] v, input logic last);
      resampled_type e;
      e.value = v;
      e.last = last;
      pending_outputs.push_back(e);
   endtask

   task automatic predict_item(input mode_type m, input logic [14:0] a,
                               input logic signed [CoefW-1:0] c,
                               input logic signed [SampleW-1:0] s);
      int n;
      bit ended;
      logic signed [SampleW-1:0] v;
      logic signed [SampleW-1:0] r;
      longint unsigned ph;
      n = 0;
      if (m == MODE_LOAD) begin
         coef_mem[a] = c;
         coef_written[a] = 1'b1;
         return;
      end
      if (m == MODE_NONE || sig_done) return;
      ended = fed_cnt != real_cnt;
      v = '0;
      if (m == MODE_SAMPLE && !ended) begin
         v = s;
         real_cnt = (real_cnt + 1) & CountMask;
      end
      ring[fed_cnt % RingDepth] = v;
      fed_cnt = (fed_cnt + 1) & CountMask;
      forever begin
         ended = fed_cnt != real_cnt;
         if (n >= ResMax) break;
         if (ended && int_pos >= real_cnt) begin
            if (held_ok) begin
               push_output(held_value, 1'b1);
               n++;
               held_ok = 1'b0;
            end
            sig_done = 1'b1;
            break;
         end
         if (!(int_pos + longint'(eff_half()) < fed_cnt)) break;
         r = fir_output();
         ph = phase + longint'(eff_down());
         int_pos = (int_pos + ph / longint'(eff_up())) & CountMask;
         phase = ph % longint'(eff_up());
         if (held_ok) begin
            push_output(held_value, 1'b0);
            n++;
         end
         held_value = r;
         held_ok = 1'b1;
      end
   endtask

   task automatic send_item(input mode_type m, input logic [14:0] a,
                            input logic signed [CoefW-1:0] c,
                            input logic signed [SampleW-1:0] s);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= m;
      req_ch.coef_addr  <= a;
      req_ch.coef_value <= c;
      req_ch.sample_in  <= s;
      do @(posedge clock); while (!req_ch.ready);
      predict_item(m, a, c, s);
      items_sent++;
   endtask

   task automatic send_sample(input logic signed [SampleW-1:0] s);
      send_item(MODE_SAMPLE, 15'($urandom), 18'($urandom), s);
   endtask

   // lower valid, let every expected item arrive, then let the block settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 4'(int'(idx) * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_UP:   up_reg   = value & 32'h1FF;
         REG_DOWN: down_reg = value & 32'hFFFF;
         default:  half_reg = value & 32'h7F;
      endcase
   endtask

   task automatic csr_check(input reg_index_type idx);
      logic [31:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= 4'(int'(idx) * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_UP:   want = up_reg;
         REG_DOWN: want = down_reg;
         default:  want = half_reg;
      endcase
      if (csr_prdata !== want) begin
         failures++;
         $display("register %0d read 0x%0h, expected 0x%0h", int'(idx), csr_prdata, want);
      end
   endtask

   task automatic configure(input int unsigned up, input int unsigned down,
                            input int unsigned half);
      csr_write(REG_UP, up);
      csr_write(REG_DOWN, down);
      csr_write(REG_HALF, half);
   endtask

   // load every coefficient the coming outputs can read
   task automatic load_bank();
      int a;
      for (int p = 0; p < 256; p++) begin
         if (p < eff_up() || longint'(p) == phase) begin
            for (int t = 0; t < 2 * eff_half(); t++) begin
               a = p * TapStride + t;
               if (!coef_written[a] || $urandom_range(0, 7) == 0)
                  send_item(MODE_LOAD, 15'(a), 18'($urandom), 24'($urandom));
            end
         end
      end
   endtask

   function automatic logic signed [SampleW-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return 24'($signed($urandom_range(0, 255)) - 128);
         default: return 24'($urandom);
      endcase
   endfunction

   // random samples, with some noise: ignored items and coefficient rewrites
   task automatic random_stream(input int count);
      int a;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 19))
            0: send_item(MODE_NONE, 15'($urandom), 18'($urandom), 24'($urandom));
            1: begin
               a = int'($urandom_range(0, eff_up() - 1)) * TapStride
                   + int'($urandom_range(0, 2 * eff_half() - 1));
               send_item(MODE_LOAD, 15'(a), 18'($urandom), 24'($urandom));
            end
            2: send_item(MODE_LOAD, 15'($urandom), 18'($urandom), 24'($urandom));
            default: send_sample(random_sample());
         endcase
      end
   endtask

   task automatic run_phase(input int unsigned up, input int unsigned down,
                            input int unsigned half, input int count);
      wait_idle();
      configure(up, down, half);
      load_bank();
      no_gaps = ($urandom_range(0, 3) == 0);
      random_stream(count);
   endtask

   task automatic test_registers();
      configure(511, 65535, 127);
      csr_check(REG_UP);
      csr_check(REG_DOWN);
      csr_check(REG_HALF);
      configure(0, 0, 0);
      csr_check(REG_UP);
      csr_check(REG_DOWN);
      csr_check(REG_HALF);
   endtask

   task automatic test_directed();
      configure(1, 1, 1);
      send_item(MODE_LOAD, 15'd0, 18'sh1FFFF, 24'd0);
      send_item(MODE_LOAD, 15'd1, 18'sh20000, 24'd0);
      send_item(MODE_LOAD, 15'd32767, 18'sh20000, 24'sh7FFFFF);
      send_sample(24'sh7FFFFF);
      send_sample(24'sh800000);
      send_item(MODE_NONE, 15'h7FFF, 18'sh1FFFF, 24'sh7FFFFF);
      send_sample(24'sh000000);
      send_sample(24'sh800000);
      send_item(MODE_LOAD, 15'd1, 18'sh1FFFF, 24'd0);
      send_sample(24'sh800000);
      send_sample(24'sh7FFFFF);
      send_item(MODE_LOAD, 15'd0, 18'sh00001, 24'd0);
      send_sample(24'sh000001);
      send_sample(24'shFFFFFF);
   endtask

   // the large position step goes last: it leaves the stream with no further outputs
   task automatic test_ratio_sweep();
      run_phase(3, 2, 4, 25);
      run_phase(16, 15, 1, 20);
      run_phase(2, 3, 2, 20);
      run_phase(0, 0, 0, 15);
      run_phase(1, 2, 5, 15);
      run_phase(7, 5, 6, 25);
      run_phase(9, 1, 1, 6);
      run_phase(5, 65535, 3, 15);
   endtask

   task automatic test_backpressure();
      run_phase(4, 3, 2, 0);
      no_gaps = 1'b1;
      hold_request = 2500;
      for (int i = 0; i < 40; i++) send_sample(random_sample());
      wait_idle();
      no_gaps = 1'b0;
      random_stream(20);
   endtask

   task automatic test_signal_end();
      int guard;
      wait_idle();
      send_item(MODE_FLUSH, 15'($urandom), 18'($urandom), 24'($urandom));
      send_sample(24'sh7FFFFF);
      send_item(MODE_NONE, 15'd0, 18'd0, 24'd0);
      send_sample(24'sh800000);
      guard = 0;
      while (!sig_done && guard < 400) begin
         send_item(MODE_FLUSH, 15'($urandom), 18'($urandom), 24'($urandom));
         guard++;
      end
      send_sample(random_sample());
      send_item(MODE_FLUSH, 15'd0, 18'd0, 24'd0);
      send_item(MODE_LOAD, 15'h4000, 18'sh15555, 24'd0);
      send_sample(random_sample());
      wait_idle();
   endtask

   // result side: check each item, stall at random, hold off on request
   always @(posedge clock) begin
      resampled_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_cnt = 0;
         stall_cnt = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (pending_outputs.size() == 0) begin
               failures++;
               if (mismatches < 10)
                  $display("unexpected item: sample_out=%0d is_last=%0b",
                           rsp_ch.sample_out, rsp_ch.is_last);
               mismatches++;
            end else begin
               e = pending_outputs.pop_front();
               if (rsp_ch.sample_out !== e.value || rsp_ch.is_last !== e.last) begin
                  failures++;
                  if (mismatches < 10)
                     $display("item %0d: sample_out=%0d is_last=%0b, expected %0d %0b",
                              results_seen, rsp_ch.sample_out, rsp_ch.is_last,
                              e.value, e.last);
                  mismatches++;
               end
            end
            stall_cnt = draw_gap();
         end
         if (hold_request > 0) begin
            hold_cnt = hold_request;
            hold_request = 0;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_cnt > 0) begin
            stall_cnt--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("timeout: %0d items still expected", pending_outputs.size());
      $display("polyphase_rational_resampler_unit_tb failed");
      $finish;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_NONE;
      req_ch.coef_addr = '0;
      req_ch.coef_value = '0;
      req_ch.sample_in = '0;
      for (int i = 0; i < 32768; i++) begin
         coef_mem[i] = '0;
         coef_written[i] = 1'b0;
      end
      for (int i = 0; i < RingDepth; i++) ring[i] = '0;
      real_cnt = 0; fed_cnt = 0; int_pos = 0; phase = 0;
      sig_done = 1'b0; held_ok = 1'b0; held_value = '0;
      up_reg = 1; down_reg = 1; half_reg = 32;
      mismatches = 0; failures = 0; results_seen = 0; items_sent = 0;
      no_gaps = 1'b0; hold_request = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_registers();
      test_directed();
      test_backpressure();
      test_ratio_sweep();
      test_signal_end();

      if (pending_outputs.size() != 0) begin
         failures++;
         $display("%0d expected items never arrived", pending_outputs.size());
      end
      $display("covered: %0d input items over ten ratio and tap settings, %0d results",
               items_sent, results_seen);
      $display("with a long result hold-off, end of signal, flush and ignored items");
      if (failures == 0)
         $display("polyphase_rational_resampler_unit_tb passed");
      else
         $display("polyphase_rational_resampler_unit_tb failed");
      $finish;
   end

endmodule
